FILE: rtl/v3alu_pkg.sv
`default_nettype none

package v3alu_pkg;

   localparam int DATA_WIDTH = 32;
   localparam int FRAC_BITS  = 16;

   localparam int PROD_W = 2 * DATA_WIDTH;      // full product / radicand
   localparam int NUM_W  = 2 * DATA_WIDTH - 1;  // divider dividend magnitude
   localparam int WIDE_W = 2 * DATA_WIDTH + 2;  // widest intermediate before saturation
   localparam int ROOT_W = DATA_WIDTH;          // square root width, one stage per bit

   localparam logic [3:0] FUNC_ADD    = 4'd0;
   localparam logic [3:0] FUNC_SUB    = 4'd1;
   localparam logic [3:0] FUNC_CROSS  = 4'd2;
   localparam logic [3:0] FUNC_MUL    = 4'd3;
   localparam logic [3:0] FUNC_SCALE  = 4'd4;
   localparam logic [3:0] FUNC_DIV    = 4'd5;
   localparam logic [3:0] FUNC_SETLEN = 4'd6;
   localparam logic [3:0] FUNC_DOT    = 4'd7;
   localparam logic [3:0] FUNC_MAG    = 4'd8;

   localparam logic signed [WIDE_W-1:0] SAT_HI =
      {{(WIDE_W-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
   localparam logic signed [WIDE_W-1:0] SAT_LO =
      {{(WIDE_W-DATA_WIDTH+1){1'b1}}, {(DATA_WIDTH-1){1'b0}}};

   typedef struct packed {
      logic [3:0]                   func;
      logic signed [DATA_WIDTH-1:0] a_x;
      logic signed [DATA_WIDTH-1:0] a_y;
      logic signed [DATA_WIDTH-1:0] a_z;
      logic signed [DATA_WIDTH-1:0] b_x;
      logic signed [DATA_WIDTH-1:0] b_y;
      logic signed [DATA_WIDTH-1:0] b_z;
      logic signed [DATA_WIDTH-1:0] scalar;
   } req_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] r_x;
      logic signed [DATA_WIDTH-1:0] r_y;
      logic signed [DATA_WIDTH-1:0] r_z;
      logic signed [DATA_WIDTH-1:0] r_scalar;
      logic                         err;
   } rsp_type;

   // travels alongside the square root stages
   typedef struct packed {
      rsp_type                    direct;
      logic                       op_div;
      logic                       op_setlen;
      logic                       op_mag;
      logic [2:0]                 neg;
      logic [DATA_WIDTH-1:0]      s_mag;
      logic [2:0][NUM_W-1:0]      num;
   } mid_type;

   // travels alongside the divider stages
   typedef struct packed {
      rsp_type    direct;
      logic       use_quot;
      logic [2:0] neg;
   } div_side_type;

   function automatic logic signed [DATA_WIDTH-1:0] sat_word(
      input logic signed [WIDE_W-1:0] v);
      logic signed [DATA_WIDTH-1:0] r;
      if (v > SAT_HI) begin
         r = SAT_HI[DATA_WIDTH-1:0];
      end else if (v < SAT_LO) begin
         r = SAT_LO[DATA_WIDTH-1:0];
      end else begin
         r = v[DATA_WIDTH-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/v3alu_front.sv
`default_nettype none

// input register, multiplier stage, combine stage
module v3alu_front (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 adv,
   input  wire logic                                 req_valid,
   input  wire v3alu_pkg::req_type                   req_data,
   output logic                                      mid_valid,
   output v3alu_pkg::mid_type                        mid_data,
   output logic [v3alu_pkg::PROD_W-1:0]              mid_rad
);

   localparam int DW = v3alu_pkg::DATA_WIDTH;
   localparam int PW = v3alu_pkg::PROD_W;
   localparam int WW = v3alu_pkg::WIDE_W;
   localparam int NW = v3alu_pkg::NUM_W;
   localparam int FB = v3alu_pkg::FRAC_BITS;

   // stage A: input register
   logic              in_valid_ff;
   v3alu_pkg::req_type in_req_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (adv) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         in_req_ff <= req_data;
      end
   end

   // stage B: six multipliers, operands picked per operation
   logic signed [DW-1:0] av [3];
   logic signed [DW-1:0] bv [3];
   logic signed [DW-1:0] opl [6];
   logic signed [DW-1:0] opr [6];
   logic signed [PW-1:0] prod_in [6];
   logic signed [DW:0]   sum_in [3];
   logic                 is_cross;
   logic                 use_s;

   always_comb begin
      av[0]    = in_req_ff.a_x;
      av[1]    = in_req_ff.a_y;
      av[2]    = in_req_ff.a_z;
      bv[0]    = in_req_ff.b_x;
      bv[1]    = in_req_ff.b_y;
      bv[2]    = in_req_ff.b_z;
      is_cross = (in_req_ff.func == v3alu_pkg::FUNC_CROSS);
      use_s    = (in_req_ff.func == v3alu_pkg::FUNC_SCALE) ||
                 (in_req_ff.func == v3alu_pkg::FUNC_SETLEN);
   end

   // cross: r[i] = m[i] - m[i+3]; squares of a land in m[3..5]
   for (genvar i = 0; i < 3; i++) begin : g_ops
      assign opl[i]   = is_cross ? av[(i+1)%3] : av[i];
      assign opr[i]   = is_cross ? bv[(i+2)%3] : (use_s ? in_req_ff.scalar : bv[i]);
      assign opl[i+3] = is_cross ? av[(i+2)%3] : av[i];
      assign opr[i+3] = is_cross ? bv[(i+1)%3] : av[i];
      assign sum_in[i] = (in_req_ff.func == v3alu_pkg::FUNC_SUB) ?
                         ((DW+1)'(av[i]) - (DW+1)'(bv[i])) :
                         ((DW+1)'(av[i]) + (DW+1)'(bv[i]));
   end

   for (genvar j = 0; j < 6; j++) begin : g_mul
      assign prod_in[j] = PW'(opl[j]) * PW'(opr[j]);
   end

   logic                 mul_valid_ff;
   logic [3:0]           mul_func_ff;
   logic signed [PW-1:0] mul_prod_ff [6];
   logic signed [DW:0]   mul_sum_ff [3];
   logic signed [DW-1:0] mul_a_ff [3];
   logic signed [DW-1:0] mul_s_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
      end else if (adv) begin
         mul_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mul_func_ff <= in_req_ff.func;
         mul_s_ff    <= in_req_ff.scalar;
         for (int j = 0; j < 6; j++) begin
            mul_prod_ff[j] <= prod_in[j];
         end
         for (int i = 0; i < 3; i++) begin
            mul_sum_ff[i] <= sum_in[i];
            mul_a_ff[i]   <= av[i];
         end
      end
   end

   // stage C: sums, floor shifts, saturation, divider operands
   logic signed [PW:0]   cr_diff [3];
   logic signed [PW:0]   cr_floor [3];
   logic signed [PW-1:0] pr_floor [3];
   logic signed [WW-1:0] dot_sum;
   logic signed [WW-1:0] dot_floor;
   logic [PW-1:0]        sq_in;
   logic [DW-1:0]        a_abs [3];
   logic [PW-1:0]        p_abs [3];
   logic [DW-1:0]        s_abs;
   logic                 err_in;
   v3alu_pkg::rsp_type   direct_in;
   v3alu_pkg::mid_type   mid_in;

   for (genvar i = 0; i < 3; i++) begin : g_comb
      assign cr_diff[i]  = (PW+1)'(mul_prod_ff[i]) - (PW+1)'(mul_prod_ff[i+3]);
      assign cr_floor[i] = cr_diff[i] >>> FB;
      assign pr_floor[i] = mul_prod_ff[i] >>> FB;
      assign a_abs[i]    = mul_a_ff[i][DW-1] ? DW'(-mul_a_ff[i]) : DW'(mul_a_ff[i]);
      assign p_abs[i]    = mul_prod_ff[i][PW-1] ? PW'(-mul_prod_ff[i]) :
                                                  PW'(mul_prod_ff[i]);
   end

   assign dot_sum   = WW'(mul_prod_ff[0]) + WW'(mul_prod_ff[1]) + WW'(mul_prod_ff[2]);
   assign dot_floor = dot_sum >>> FB;
   assign sq_in     = PW'($unsigned(mul_prod_ff[3])) + PW'($unsigned(mul_prod_ff[4])) +
                      PW'($unsigned(mul_prod_ff[5]));
   assign s_abs     = mul_s_ff[DW-1] ? DW'(-mul_s_ff) : DW'(mul_s_ff);
   assign err_in    = ((mul_func_ff == v3alu_pkg::FUNC_DIV) && (mul_s_ff == '0)) ||
                      ((mul_func_ff == v3alu_pkg::FUNC_SETLEN) && (sq_in == '0));

   always_comb begin
      direct_in = '0;
      unique case (mul_func_ff) inside
         v3alu_pkg::FUNC_ADD, v3alu_pkg::FUNC_SUB: begin
            direct_in.r_x = v3alu_pkg::sat_word(WW'(mul_sum_ff[0]));
            direct_in.r_y = v3alu_pkg::sat_word(WW'(mul_sum_ff[1]));
            direct_in.r_z = v3alu_pkg::sat_word(WW'(mul_sum_ff[2]));
         end
         v3alu_pkg::FUNC_CROSS: begin
            direct_in.r_x = v3alu_pkg::sat_word(WW'(cr_floor[0]));
            direct_in.r_y = v3alu_pkg::sat_word(WW'(cr_floor[1]));
            direct_in.r_z = v3alu_pkg::sat_word(WW'(cr_floor[2]));
         end
         v3alu_pkg::FUNC_MUL, v3alu_pkg::FUNC_SCALE: begin
            direct_in.r_x = v3alu_pkg::sat_word(WW'(pr_floor[0]));
            direct_in.r_y = v3alu_pkg::sat_word(WW'(pr_floor[1]));
            direct_in.r_z = v3alu_pkg::sat_word(WW'(pr_floor[2]));
         end
         v3alu_pkg::FUNC_DOT: begin
            direct_in.r_scalar = v3alu_pkg::sat_word(dot_floor);
         end
         default: begin
            direct_in = '0;
         end
      endcase
      if (err_in) begin
         direct_in     = '0;
         direct_in.err = 1'b1;
      end
   end

   always_comb begin
      mid_in           = '0;
      mid_in.direct    = direct_in;
      mid_in.op_div    = (mul_func_ff == v3alu_pkg::FUNC_DIV);
      mid_in.op_setlen = (mul_func_ff == v3alu_pkg::FUNC_SETLEN);
      mid_in.op_mag    = (mul_func_ff == v3alu_pkg::FUNC_MAG);
      mid_in.s_mag     = s_abs;
      for (int i = 0; i < 3; i++) begin
         if (mul_func_ff == v3alu_pkg::FUNC_SETLEN) begin
            mid_in.num[i] = p_abs[i][NW-1:0];
            mid_in.neg[i] = mul_prod_ff[i][PW-1];
         end else begin
            mid_in.num[i] = NW'(a_abs[i]) << FB;
            mid_in.neg[i] = mul_a_ff[i][DW-1] ^ mul_s_ff[DW-1];
         end
      end
   end

   logic               mid_valid_ff;
   v3alu_pkg::mid_type mid_ff;
   logic [PW-1:0]      rad_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_valid_ff <= 1'b0;
      end else if (adv) begin
         mid_valid_ff <= mul_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mid_ff <= mid_in;
         rad_ff <= sq_in;
      end
   end

   assign mid_valid = mid_valid_ff;
   assign mid_data  = mid_ff;
   assign mid_rad   = rad_ff;

endmodule

`default_nettype wire

FILE: rtl/v3alu_sqrt.sv
`default_nettype none

// pipelined integer square root, one root bit per stage
module v3alu_sqrt (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          adv,
   input  wire logic                          in_valid,
   input  wire logic [v3alu_pkg::PROD_W-1:0]  in_rad,
   input  wire v3alu_pkg::mid_type            in_side,
   output logic                               out_valid,
   output logic [v3alu_pkg::ROOT_W-1:0]       out_root,
   output v3alu_pkg::mid_type                 out_side
);

   localparam int PW = v3alu_pkg::PROD_W;
   localparam int RW = v3alu_pkg::ROOT_W;
   localparam int MW = RW + 2;   // partial remainder stays below 2*root+1
   localparam int TW = MW + 2;

   logic               valid_ff [RW];
   logic [PW-1:0]      rad_ff   [RW];
   logic [MW-1:0]      rem_ff   [RW];
   logic [RW-1:0]      root_ff  [RW];
   v3alu_pkg::mid_type side_ff  [RW];

   for (genvar k = 0; k < RW; k++) begin : g_stage
      logic               prv_valid;
      logic [PW-1:0]      prv_rad;
      logic [MW-1:0]      prv_rem;
      logic [RW-1:0]      prv_root;
      v3alu_pkg::mid_type prv_side;
      logic [TW-1:0]      rem_try;
      logic [TW-1:0]      trial;
      logic [TW-1:0]      diff;
      logic               ge;
      logic [MW-1:0]      rem_in;
      logic [RW-1:0]      root_in;

      if (k == 0) begin : g_first
         assign prv_valid = in_valid;
         assign prv_rad   = in_rad;
         assign prv_rem   = '0;
         assign prv_root  = '0;
         assign prv_side  = in_side;
      end else begin : g_next
         assign prv_valid = valid_ff[k-1];
         assign prv_rad   = rad_ff[k-1];
         assign prv_rem   = rem_ff[k-1];
         assign prv_root  = root_ff[k-1];
         assign prv_side  = side_ff[k-1];
      end

      assign rem_try = {prv_rem, prv_rad[PW-1:PW-2]};
      assign trial   = TW'({prv_root, 2'b01});
      assign diff    = rem_try - trial;
      assign ge      = (rem_try >= trial);
      assign rem_in  = ge ? diff[MW-1:0] : rem_try[MW-1:0];
      assign root_in = {prv_root[RW-2:0], ge};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (adv) begin
            valid_ff[k] <= prv_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rad_ff[k]  <= prv_rad << 2;
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            side_ff[k] <= prv_side;
         end
      end
   end

   assign out_valid = valid_ff[RW-1];
   assign out_root  = root_ff[RW-1];
   assign out_side  = side_ff[RW-1];

endmodule

`default_nettype wire

FILE: rtl/v3alu_div.sv
`default_nettype none

// three-lane pipelined restoring divider, one quotient bit per stage
module v3alu_div (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  adv,
   input  wire logic                                  in_valid,
   input  wire logic [2:0][v3alu_pkg::NUM_W-1:0]      in_num,
   input  wire logic [v3alu_pkg::DATA_WIDTH-1:0]      in_den,
   input  wire v3alu_pkg::div_side_type               in_side,
   output logic                                       out_valid,
   output logic [2:0][v3alu_pkg::NUM_W-1:0]           out_quot,
   output v3alu_pkg::div_side_type                    out_side
);

   localparam int NW = v3alu_pkg::NUM_W;
   localparam int DW = v3alu_pkg::DATA_WIDTH;

   logic                    valid_ff [NW];
   logic [DW-1:0]           den_ff   [NW];
   logic [2:0][DW-1:0]      rem_ff   [NW];
   logic [2:0][NW-1:0]      nq_ff    [NW];   // dividend shifts out, quotient in
   v3alu_pkg::div_side_type side_ff  [NW];

   for (genvar k = 0; k < NW; k++) begin : g_stage
      logic                    prv_valid;
      logic [DW-1:0]           prv_den;
      logic [2:0][DW-1:0]      prv_rem;
      logic [2:0][NW-1:0]      prv_nq;
      v3alu_pkg::div_side_type prv_side;
      logic [2:0][DW-1:0]      rem_in;
      logic [2:0][NW-1:0]      nq_in;

      if (k == 0) begin : g_first
         assign prv_valid = in_valid;
         assign prv_den   = in_den;
         assign prv_rem   = '0;
         assign prv_nq    = in_num;
         assign prv_side  = in_side;
      end else begin : g_next
         assign prv_valid = valid_ff[k-1];
         assign prv_den   = den_ff[k-1];
         assign prv_rem   = rem_ff[k-1];
         assign prv_nq    = nq_ff[k-1];
         assign prv_side  = side_ff[k-1];
      end

      for (genvar l = 0; l < 3; l++) begin : g_lane
         logic [DW:0] try_val;
         logic [DW:0] diff;
         logic        ge;

         assign try_val     = {prv_rem[l], prv_nq[l][NW-1]};
         assign diff        = try_val - {1'b0, prv_den};
         assign ge          = (try_val >= {1'b0, prv_den});
         assign rem_in[l]   = ge ? diff[DW-1:0] : try_val[DW-1:0];
         assign nq_in[l]    = {prv_nq[l][NW-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (adv) begin
            valid_ff[k] <= prv_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            den_ff[k]  <= prv_den;
            rem_ff[k]  <= rem_in;
            nq_ff[k]   <= nq_in;
            side_ff[k] <= prv_side;
         end
      end
   end

   assign out_valid = valid_ff[NW-1];
   assign out_quot  = nq_ff[NW-1];
   assign out_side  = side_ff[NW-1];

endmodule

`default_nettype wire

FILE: rtl/vector3_alu.sv
`default_nettype none

// Channel   Direction  Handshake              Payload
// req       in         req_valid / req_ready  req_data (func, a, b, scalar)
// rsp       out        rsp_valid / rsp_ready  rsp_data (r vector, r_scalar, err)
//
// One item per cycle unless the output stalls; 3 front stages (input
// register, multipliers, sums), 32 square root stages, 63 divider stages
// and the output register. Every item walks the full pipe.
// Reset (synchronous) clears only the valid bits of the stages.
// A result left waiting at the output freezes the whole pipe; req_ready
// drops in that same cycle and no item is lost or repeated.
module vector3_alu (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire v3alu_pkg::req_type req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output v3alu_pkg::rsp_type      rsp_data
);

   localparam int DW = v3alu_pkg::DATA_WIDTH;
   localparam int NW = v3alu_pkg::NUM_W;
   localparam int PW = v3alu_pkg::PROD_W;
   localparam int RW = v3alu_pkg::ROOT_W;
   localparam int WW = v3alu_pkg::WIDE_W;

   logic                    rsp_valid_ff;
   v3alu_pkg::rsp_type      rsp_ff;
   logic                    adv;

   // pipe moves whenever the output register is free or being drained
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;

   logic               mid_valid;
   v3alu_pkg::mid_type mid_data;
   logic [PW-1:0]      mid_rad;

   v3alu_front u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .req_valid (req_valid),
      .req_data  (req_data),
      .mid_valid (mid_valid),
      .mid_data  (mid_data),
      .mid_rad   (mid_rad)
   );

   logic               sq_valid;
   logic [RW-1:0]      sq_root;
   v3alu_pkg::mid_type sq_side;

   v3alu_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (mid_valid),
      .in_rad    (mid_rad),
      .in_side   (mid_data),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   // magnitude is final here; set length divides by the root,
   // divide by |scalar|
   logic signed [WW-1:0]    root_wide;
   v3alu_pkg::div_side_type dv_side_in;
   logic [DW-1:0]           dv_den_in;

   assign root_wide = WW'(sq_root);
   assign dv_den_in = sq_side.op_setlen ? DW'(sq_root) : sq_side.s_mag;

   always_comb begin
      dv_side_in          = '0;
      dv_side_in.direct   = sq_side.direct;
      dv_side_in.neg      = sq_side.neg;
      dv_side_in.use_quot = (sq_side.op_div || sq_side.op_setlen) && !sq_side.direct.err;
      if (sq_side.op_mag) begin
         dv_side_in.direct          = '0;
         dv_side_in.direct.r_scalar = v3alu_pkg::sat_word(root_wide);
      end
   end

   logic                    dv_valid;
   logic [2:0][NW-1:0]      dv_quot;
   v3alu_pkg::div_side_type dv_side;

   v3alu_div u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (sq_valid),
      .in_num    (sq_side.num),
      .in_den    (dv_den_in),
      .in_side   (dv_side_in),
      .out_valid (dv_valid),
      .out_quot  (dv_quot),
      .out_side  (dv_side)
   );

   // sign fix and saturation of the quotients (truncation toward zero)
   logic signed [WW-1:0]    q_mag [3];
   logic signed [WW-1:0]    q_val [3];
   logic signed [DW-1:0]    q_sat [3];
   v3alu_pkg::rsp_type      rsp_in;

   for (genvar l = 0; l < 3; l++) begin : g_quot
      assign q_mag[l] = WW'(dv_quot[l]);
      assign q_val[l] = dv_side.neg[l] ? -q_mag[l] : q_mag[l];
      assign q_sat[l] = v3alu_pkg::sat_word(q_val[l]);
   end

   always_comb begin
      rsp_in = dv_side.direct;
      if (dv_side.use_quot) begin
         rsp_in     = '0;
         rsp_in.r_x = q_sat[0];
         rsp_in.r_y = q_sat[1];
         rsp_in.r_z = q_sat[2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

FILE: rtl/vector3_alu_chk.sv
`default_nettype none

module vector3_alu_chk (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_ready,
   input wire v3alu_pkg::req_type req_data,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire v3alu_pkg::rsp_type rsp_data
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // input only blocks behind a stalled output
   a_ready: assert property (@(posedge clock)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input blocked without output stall");

   // reset empties the pipe
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // error items carry zeros
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.err |->
         rsp_data.r_x == '0 && rsp_data.r_y == '0 &&
         rsp_data.r_z == '0 && rsp_data.r_scalar == '0)
      else $error("error item with nonzero fields");

   // scalar results never come with a vector
   a_scalar_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.r_scalar != '0 |->
         rsp_data.r_x == '0 && rsp_data.r_y == '0 && rsp_data.r_z == '0)
      else $error("scalar and vector both nonzero");

endmodule

bind vector3_alu vector3_alu_chk u_chk (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire
